>>> hw/rtl/fpat_pkg.sv
// shared constants and types of the fixed-point arctangent unit
`default_nettype none
package fpat_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WB            = 30;
  localparam int ANG_W         = 18;

  localparam logic [1:0] OP_ATAN = 2'd0;
  localparam logic [1:0] OP_ACOT = 2'd1;
  localparam logic [1:0] OP_ASIN = 2'd2;

  // polynomial coefficients, Q2.30
  localparam logic [26:0]        COEF_A    = 27'd83377080;
  localparam logic signed [33:0] COEF_B    = -34'sd308630418;
  localparam logic signed [33:0] COEF_C    = 34'sd1068568194;
  localparam logic signed [33:0] HALF_PI_W = 34'sd1686629713;
  localparam logic [63:0]        HALF_LSB  = 64'd1 << (WB - 1);

  typedef struct packed {
    logic [1:0]       op;
    logic             neg;
    logic             spec;
    logic             err;
    logic [ANG_W-1:0] spec_angle;
    logic [31:0]      mag;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic             spec;
    logic             err;
    logic [ANG_W-1:0] spec_angle;
    logic             zero;
    logic             recip;
    logic [30:0]      tdir;
  } arc_t;

  localparam int SIDE_W = $bits(side_t);
  localparam int ARC_W  = $bits(arc_t);

endpackage
`default_nettype wire

>>> hw/rtl/fpat_sqrt_cell.sv
// one digit step of the pipelined integer square root
`default_nettype none
module fpat_sqrt_cell #(
  parameter int ROOT_W = 17,
  parameter int RAD_W  = 34,
  parameter int REM_W  = 20,
  parameter int SB_W   = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vld_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire logic [REM_W-1:0]  rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output logic                   vld_o,
  output logic [RAD_W-1:0]       rad_o,
  output logic [REM_W-1:0]       rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SB_W-1:0]        sb_o
);

  logic [REM_W-1:0] part;
  logic [REM_W-1:0] trial;
  logic             take;

  assign part  = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
  assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_i, 2'b01};
  assign take  = part >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_o  <= {rad_i[RAD_W-3:0], 2'b00};
    rem_o  <= take ? (part - trial) : part;
    root_o <= {root_i[ROOT_W-2:0], take};
    sb_o   <= sb_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/fpat_div_cell.sv
// one quotient bit of the pipelined restoring divider
`default_nettype none
module fpat_div_cell #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32,
  parameter int SB_W  = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] rem_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic                  vld_o,
  output logic [NUM_W-1:0]      num_o,
  output logic [DEN_W-1:0]      rem_o,
  output logic [DEN_W-1:0]      den_o,
  output logic [SB_W-1:0]       sb_o
);

  logic [DEN_W:0] part;
  logic [DEN_W:0] diff;
  logic           take;

  assign part = {rem_i, num_i[NUM_W-1]};
  assign diff = part - {1'b0, den_i};
  assign take = part >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk) begin
    num_o <= {num_i[NUM_W-2:0], take};
    rem_o <= take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
    den_o <= den_i;
    sb_o  <= sb_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/fpat_poly.sv
// fifth-order odd arctangent polynomial, fold and output rounding
`default_nettype none
module fpat_poly #(
  parameter int FRAC_BITS = fpat_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       vld_i,
  input  wire logic [30:0]                t_i,
  input  wire fpat_pkg::arc_t             sb_i,
  output logic                            vld_o,
  output logic [fpat_pkg::ANG_W-1:0]      angle_o,
  output logic                            err_o
);
  import fpat_pkg::*;

  localparam int          S   = WB - FRAC_BITS;
  localparam logic [35:0] RND = (36'd1 << S) >> 1;

  logic [4:0] vld;
  arc_t       sb_a, sb_b, sb_c, sb_d;
  logic [30:0] t_a, t_b, t_c;
  logic [30:0] t2_b;
  logic [61:0] pa;
  logic [57:0] pb;
  logic [62:0] pc;
  logic [63:0] pd;
  logic        us_c, vs_d;

  logic [30:0]        t2;
  logic [27:0]        ra;
  logic signed [33:0] u;
  logic [33:0]        um;
  logic [32:0]        rc;
  logic signed [33:0] v;
  logic [33:0]        vm;
  logic [35:0]        rd;
  logic signed [35:0] p;
  logic signed [35:0] r;
  logic [35:0]        rpos;
  logic [35:0]        m;
  logic [35:0]        ang;
  logic [ANG_W-1:0]   res;

  always_comb begin
    t2   = 31'((64'(pa) + HALF_LSB) >> WB);
    ra   = 28'((64'(pb) + HALF_LSB) >> WB);
    u    = $signed({6'b0, ra}) + COEF_B;
    um   = u[33] ? 34'(-u) : 34'(u);
    rc   = 33'((64'(pc) + HALF_LSB) >> WB);
    v    = (us_c ? -$signed({1'b0, rc}) : $signed({1'b0, rc})) + COEF_C;
    vm   = v[33] ? 34'(-v) : 34'(v);
    rd   = 36'((pd + HALF_LSB) >> WB);
    p    = vs_d ? -$signed(rd) : $signed(rd);
    r    = sb_d.recip ? (36'(HALF_PI_W) - p) : p;
    rpos = r[35] ? 36'd0 : 36'(r);
    m    = (rpos + RND) >> S;
    ang  = sb_d.neg ? -m : m;
    if (sb_d.spec) begin
      res = sb_d.spec_angle;
    end else if (sb_d.zero) begin
      res = '0;
    end else begin
      res = ang[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_o <= 1'b0;
    end else begin
      vld   <= {vld[3:0], vld_i};
      vld_o <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    // t squared
    sb_a <= sb_i;
    t_a  <= t_i;
    pa   <= 62'(t_i) * 62'(t_i);
    // a * t2
    sb_b <= sb_a;
    t_b  <= t_a;
    t2_b <= t2;
    pb   <= 58'(COEF_A) * 58'(t2);
    // (a*t2 + b) * t2
    sb_c <= sb_b;
    t_c  <= t_b;
    us_c <= u[33];
    pc   <= 63'(um[31:0]) * 63'(t2_b);
    // (.. + c) * t
    sb_d <= sb_c;
    vs_d <= v[33];
    pd   <= 64'(vm[32:0]) * 64'(t_c);
    // fold, round, sign
    angle_o <= res;
    err_o   <= sb_d.spec & sb_d.err;
  end

endmodule
`default_nettype wire

>>> hw/rtl/fixed_point_arctangent_unit_top.sv
// fixed-point arctangent, arccotangent and fast arcsine unit
// pipeline: entry registers, the square root cells, the quotient divider cells,
//   the reciprocal cells and the polynomial stages
// throughput: one request per cycle, busy is never raised, the receiver cannot stall
// reset: synchronous rst empties the pipeline and clears the zero threshold thr to 0
`default_nettype none
module fixed_point_arctangent_unit_top #(
  parameter int FRAC_BITS = fpat_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   op,
  input  wire logic signed [31:0]           x,
  input  wire logic                         cfg_we,
  input  wire logic [15:0]                  cfg_data,
  output logic                              done,
  output logic signed [fpat_pkg::ANG_W-1:0] angle,
  output logic                              domain_error
);
  import fpat_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int S      = WB - F;
  localparam int N1_W   = ((2 * F > 30) ? 2 * F : 30) + 1;
  localparam int N2_W   = F + 31;
  localparam int DEN_W  = 32;
  localparam int RAD_W  = 2 * F + 2;
  localparam int ROOT_W = F + 1;
  localparam int REM_W  = F + 4;
  localparam int QX_W   = (N1_W > 32) ? N1_W : 32;
  localparam logic [31:0] ONE    = 32'd1 << F;
  localparam logic [33:0] HP_OUT = (34'(HALF_PI_W) + ((34'd1 << S) >> 1)) >> S;
  localparam logic [ANG_W-1:0] HP_ANG = HP_OUT[ANG_W-1:0];

  logic [15:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // entry: sign, magnitude and the cases with a fixed answer
  logic        x_neg;
  logic [31:0] x_mag;
  side_t       ent;

  always_comb begin
    x_neg          = x[31];
    x_mag          = x_neg ? (~x + 32'd1) : x;
    ent.op         = op;
    ent.neg        = x_neg;
    ent.mag        = x_mag;
    ent.spec       = 1'b0;
    ent.err        = 1'b0;
    ent.spec_angle = '0;
    case (op)
      OP_ATAN: ent.spec = 1'b0;
      OP_ACOT: begin
        ent.spec       = (x_mag == 32'd0);
        ent.spec_angle = HP_ANG;
      end
      OP_ASIN: begin
        if (x_mag > ONE) begin
          ent.spec = 1'b1;
          ent.err  = 1'b1;
        end else if (x_mag == ONE) begin
          ent.spec       = 1'b1;
          ent.spec_angle = x_neg ? -HP_ANG : HP_ANG;
        end
      end
      default: ent.spec = 1'b1;
    endcase
  end

  logic             vld1, vld2;
  side_t            sb1, sb2;
  logic [RAD_W-1:0] rad2;
  logic [2*F-1:0]   sq;

  function automatic logic [2*F-1:0] s1_sq(input logic [F-1:0] a);
    s1_sq = (2*F)'(a) * (2*F)'(a);
  endfunction

  assign sq = s1_sq(sb1.mag[F-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= start;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    sb1  <= ent;
    sb2  <= sb1;
    rad2 <= (RAD_W'(1) << (2 * F)) - RAD_W'(sq);
  end

  // square root cells
  logic              sq_vld  [ROOT_W+1];
  logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
  logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [SIDE_W-1:0] sq_sb   [ROOT_W+1];

  assign sq_vld[0]  = vld2;
  assign sq_rad[0]  = rad2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = SIDE_W'(sb2);

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    fpat_sqrt_cell #(
      .ROOT_W(ROOT_W), .RAD_W(RAD_W), .REM_W(REM_W), .SB_W(SIDE_W)
    ) u_cell (
      .clk(clk), .rst(rst),
      .vld_i(sq_vld[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
      .root_i(sq_root[i]), .sb_i(sq_sb[i]),
      .vld_o(sq_vld[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .sb_o(sq_sb[i+1])
    );
  end

  // quotient operands: 1/x for arccotangent, x/sqrt(1-x^2) for arcsine
  side_t             sb3;
  logic [ROOT_W-1:0] s_fix;
  logic [N1_W-1:0]   num1;
  logic [DEN_W-1:0]  den1;

  always_comb begin
    sb3   = side_t'(sq_sb[ROOT_W]);
    s_fix = (sq_root[ROOT_W] == '0) ? ROOT_W'(1) : sq_root[ROOT_W];
    if (sb3.op == OP_ACOT) begin
      num1 = (N1_W'(1) << (2 * F)) + N1_W'(sb3.mag >> 1);
      den1 = sb3.mag;
    end else begin
      num1 = (N1_W'(sb3.mag[F-1:0]) << F) + N1_W'(s_fix >> 1);
      den1 = DEN_W'(s_fix);
    end
  end

  logic              d1_vld [N1_W+1];
  logic [N1_W-1:0]   d1_num [N1_W+1];
  logic [DEN_W-1:0]  d1_rem [N1_W+1];
  logic [DEN_W-1:0]  d1_den [N1_W+1];
  logic [SIDE_W-1:0] d1_sb  [N1_W+1];

  assign d1_vld[0] = sq_vld[ROOT_W];
  assign d1_num[0] = num1;
  assign d1_rem[0] = '0;
  assign d1_den[0] = den1;
  assign d1_sb[0]  = sq_sb[ROOT_W];

  for (genvar i = 0; i < N1_W; i++) begin : g_div1
    fpat_div_cell #(.NUM_W(N1_W), .DEN_W(DEN_W), .SB_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst),
      .vld_i(d1_vld[i]), .num_i(d1_num[i]), .rem_i(d1_rem[i]),
      .den_i(d1_den[i]), .sb_i(d1_sb[i]),
      .vld_o(d1_vld[i+1]), .num_o(d1_num[i+1]), .rem_o(d1_rem[i+1]),
      .den_o(d1_den[i+1]), .sb_o(d1_sb[i+1])
    );
  end

  // arctangent argument: saturate the quotient, pick the reciprocal path
  side_t           sb4;
  logic [QX_W-1:0] qx, lim, qs;
  logic [31:0]     y_mag;
  arc_t            arc;

  always_comb begin
    sb4   = side_t'(d1_sb[N1_W]);
    qx    = QX_W'(d1_num[N1_W]);
    lim   = sb4.neg ? (QX_W'(1) << 31) : ((QX_W'(1) << 31) - QX_W'(1));
    qs    = (qx > lim) ? lim : qx;
    y_mag = (sb4.op == OP_ATAN) ? sb4.mag : qs[31:0];
    arc.neg        = sb4.neg;
    arc.spec       = sb4.spec;
    arc.err        = sb4.err;
    arc.spec_angle = sb4.spec_angle;
    arc.zero       = y_mag <= 32'(thr);
    arc.recip      = y_mag > ONE;
    arc.tdir       = 31'(y_mag[F:0]) << S;
  end

  logic             vld5;
  arc_t             arc5;
  logic [N2_W-1:0]  num5;
  logic [DEN_W-1:0] den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= d1_vld[N1_W];
    end
  end

  always_ff @(posedge clk) begin
    arc5 <= arc;
    num5 <= (N2_W'(1) << (WB + F)) + N2_W'(y_mag >> 1);
    den5 <= y_mag;
  end

  // reciprocal cells for arguments above one
  logic             d2_vld [N2_W+1];
  logic [N2_W-1:0]  d2_num [N2_W+1];
  logic [DEN_W-1:0] d2_rem [N2_W+1];
  logic [DEN_W-1:0] d2_den [N2_W+1];
  logic [ARC_W-1:0] d2_sb  [N2_W+1];

  assign d2_vld[0] = vld5;
  assign d2_num[0] = num5;
  assign d2_rem[0] = '0;
  assign d2_den[0] = den5;
  assign d2_sb[0]  = ARC_W'(arc5);

  for (genvar i = 0; i < N2_W; i++) begin : g_div2
    fpat_div_cell #(.NUM_W(N2_W), .DEN_W(DEN_W), .SB_W(ARC_W)) u_cell (
      .clk(clk), .rst(rst),
      .vld_i(d2_vld[i]), .num_i(d2_num[i]), .rem_i(d2_rem[i]),
      .den_i(d2_den[i]), .sb_i(d2_sb[i]),
      .vld_o(d2_vld[i+1]), .num_o(d2_num[i+1]), .rem_o(d2_rem[i+1]),
      .den_o(d2_den[i+1]), .sb_o(d2_sb[i+1])
    );
  end

  arc_t        arc6;
  logic [30:0] t6;

  assign arc6 = arc_t'(d2_sb[N2_W]);
  assign t6   = arc6.recip ? d2_num[N2_W][30:0] : arc6.tdir;

  logic [ANG_W-1:0] ang_raw;

  fpat_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk(clk), .rst(rst),
    .vld_i(d2_vld[N2_W]), .t_i(t6), .sb_i(arc6),
    .vld_o(done), .angle_o(ang_raw), .err_o(domain_error)
  );

  assign angle = $signed(ang_raw);

endmodule
`default_nettype wire

>>> sim/tb_fixed_point_arctangent_unit_top.sv
// testbench for the fixed-point arctangent unit: predicts every angle and checks it in order
`default_nettype none
module tb_fixed_point_arctangent_unit_top;
  import fpat_pkg::*;

  localparam int FB       = 16;
  localparam int LATENCY  = 105;
  localparam int LIMIT    = 400000;
  localparam longint PI2W = 64'sd1686629713;
  localparam longint CA   = 64'sd83377080;
  localparam longint CB   = -64'sd308630418;
  localparam longint CC   = 64'sd1068568194;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic                    domain_error;
  } angle_res_t;

  class angle_scoreboard;
    angle_res_t pending[$];
    longint unsigned threshold;
    int errors;

    function new();
      threshold = 0;
      errors = 0;
    endfunction

    function longint mul_round(longint a, longint b);
      logic neg;
      longint unsigned ua, ub, p;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub + (64'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function longint narrow(longint w);
      longint unsigned m;
      m = (w < 0) ? -w : w;
      m = (m + (64'd1 << 13)) >> 14;
      return (w < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint quot_sat(longint unsigned num, longint unsigned den, logic neg);
      longint unsigned q, lim;
      q = (num + den / 2) / den;
      lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint arctan_of(longint a);
      logic neg, recip;
      longint unsigned mag;
      longint t, t2, p, r;
      neg = a < 0;
      mag = neg ? -a : a;
      recip = mag > (64'd1 << FB);
      if (mag <= threshold) return 0;
      if (recip) t = ((64'd1 << (30 + FB)) + mag / 2) / mag;
      else t = mag << (30 - FB);
      t2 = mul_round(t, t);
      p = mul_round(mul_round(CA, t2) + CB, t2) + CC;
      p = mul_round(p, t);
      r = recip ? PI2W - p : p;
      if (r < 0) r = 0;
      return neg ? -narrow(r) : narrow(r);
    endfunction

    function void note_request(logic [1:0] op, logic signed [31:0] x);
      angle_res_t e;
      longint xv, ang;
      longint unsigned mag, s;
      logic neg;
      xv = x;
      neg = xv < 0;
      mag = neg ? -xv : xv;
      ang = 0;
      e.domain_error = 0;
      case (op)
        OP_ATAN: ang = arctan_of(xv);
        OP_ACOT: begin
          if (mag == 0) ang = narrow(PI2W);
          else ang = arctan_of(quot_sat(64'd1 << (2 * FB), mag, neg));
        end
        OP_ASIN: begin
          if (mag > (64'd1 << FB)) e.domain_error = 1;
          else if (mag == (64'd1 << FB)) ang = neg ? -narrow(PI2W) : narrow(PI2W);
          else begin
            s = floor_sqrt((64'd1 << (2 * FB)) - mag * mag);
            if (s == 0) s = 1;
            ang = arctan_of(quot_sat(mag << FB, s, neg));
          end
        end
        default: ang = 0;
      endcase
      e.angle = ang[ANG_W-1:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [ANG_W-1:0] angle, logic derr);
      angle_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result angle=%0d domain_error=%0b", angle, derr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (angle !== e.angle) begin
        $error("angle expected %0d actual %0d", e.angle, angle);
        errors++;
      end
      if (derr !== e.domain_error) begin
        $error("domain_error expected %0b actual %0b", e.domain_error, derr);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, cfg_we;
  logic busy, done, domain_error;
  logic [1:0] op;
  logic signed [31:0] x;
  logic [15:0] cfg_data;
  logic signed [ANG_W-1:0] angle;
  int cycles;
  int idle_pct;
  angle_scoreboard sb;

  fixed_point_arctangent_unit_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .x(x),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .angle(angle),
    .domain_error(domain_error)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(angle, domain_error);
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, with random idle cycles before it
  task automatic send(input logic [1:0] o, input logic signed [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    op <= o;
    x <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(o, v);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.threshold = v;
  endtask

  function automatic logic signed [31:0] rand_arg();
    int k;
    k = $urandom_range(9);
    if (k < 3) return $urandom;
    if (k < 6) return $signed($urandom_range(131072)) - 65536;
    if (k < 8) return $signed($urandom_range(8192)) - 4096;
    return $signed($urandom_range(65536 * 64)) - 65536 * 32;
  endfunction

  initial begin
    logic signed [31:0] dir[$];
    int ph;
    sb = new();
    cycles = 0;
    idle_pct = 0;
    rst = 1;
    start = 0;
    op = OP_ATAN;
    x = 0;
    cfg_we = 0;
    cfg_data = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    dir = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, 65536, -65536, 65537, -65537,
            65535, -65535, 32768, -200000};
    foreach (dir[i]) begin
      send(OP_ATAN, dir[i]);
      send(OP_ACOT, dir[i]);
      send(OP_ASIN, dir[i]);
    end
    send(2'd3, 32'sh12345678);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_threshold(16'hffff);
        1: write_threshold(16'd0);
        2: write_threshold(16'd1);
        default: write_threshold($urandom_range(2000));
      endcase
      idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 66 : (ph % 4 == 2) ? 34 : 0;
      repeat (135) begin
        logic [1:0] o;
        o = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        send(o, rand_arg());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> fixed_point_arctangent_unit_top.f
hw/rtl/fpat_pkg.sv
hw/rtl/fpat_sqrt_cell.sv
hw/rtl/fpat_div_cell.sv
hw/rtl/fpat_poly.sv
hw/rtl/fixed_point_arctangent_unit_top.sv
sim/tb_fixed_point_arctangent_unit_top.sv
